// ===== src/i2c_target_fixed_reply_unit_defines.svh =====
// ---------------------------------------------------------------------------
// I2C target assertion macros
// Shared property wrappers for the checker; clock clk_i, reset rst_ni.
// ---------------------------------------------------------------------------
`ifndef I2C_TARGET_FIXED_REPLY_UNIT_DEFINES_SVH
`define I2C_TARGET_FIXED_REPLY_UNIT_DEFINES_SVH

// Same-cycle implication
`define I2CFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication
`define I2CFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== src/i2cfr_pkg.sv =====
// ---------------------------------------------------------------------------
// I2C target package
// Request and result types, bus phase codes and register defaults.
// ---------------------------------------------------------------------------
package i2cfr_pkg;

  // Register defaults
  localparam logic [6:0]  OWN_ADDR_RST   = 7'h22;
  localparam logic [7:0]  IDLE_TICKS_RST = 8'd5;
  localparam logic [31:0] REPLY_RST      = 32'h5566_77AA;
  localparam int unsigned REPLY_BYTES_DEF = 4;

  // Register indexes
  localparam logic [1:0] CFG_OWN_ADDR   = 2'd0;
  localparam logic [1:0] CFG_IDLE_TICKS = 2'd1;
  localparam logic [1:0] CFG_REPLY      = 2'd2;

  // Bus phase codes
  localparam logic [2:0] PH_WAIT  = 3'd0;
  localparam logic [2:0] PH_ARMED = 3'd1;
  localparam logic [2:0] PH_ADDR  = 3'd2;
  localparam logic [2:0] PH_WRITE = 3'd3;
  localparam logic [2:0] PH_READ  = 3'd4;

  typedef struct packed {
    logic scl;
    logic sda;
  } in_req_t;

  typedef struct packed {
    logic       sda_pull_low;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       led;
    logic [2:0] phase;
  } out_rsp_t;

endpackage

// ===== src/i2c_target_fixed_reply_unit.sv =====
// ---------------------------------------------------------------------------
// I2C target with fixed reply
// Samples SCL/SDA once per request, answers a 7-bit address, receives
// written bytes and sends REPLY_BYTES reply bytes on reads.
// ---------------------------------------------------------------------------
// Each request carries one sample of the SCL and SDA lines. The block takes
// one request per clock unless stalled and registers its result; throughput
// is one sample per cycle, bounded by the single update of the protocol
// state register. A result register decouples the two sides, so a new
// sample is accepted while the previous result is still being taken.
// Configuration (address, idle count, reply word) must be written while the
// bus sampling is idle. No clearing pass runs after reset.
module i2c_target_fixed_reply_unit import i2cfr_pkg::*; #(
  parameter int unsigned REPLY_BYTES = REPLY_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_req_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_rsp_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned BcW = $clog2(REPLY_BYTES + 1);

  // Sub-steps in address and write phases
  localparam logic [2:0] SS_WAIT_LOW  = 3'd0;
  localparam logic [2:0] SS_SAMPLE    = 3'd1;
  localparam logic [2:0] SS_HOLD_ONE  = 3'd2;
  localparam logic [2:0] SS_HOLD_ZERO = 3'd3;
  localparam logic [2:0] SS_ACK_RISE  = 3'd4;
  localparam logic [2:0] SS_ACK_FALL  = 3'd5;

  // Sub-steps in read phase
  localparam logic [2:0] RD_SETUP      = 3'd0;
  localparam logic [2:0] RD_CLK_HIGH   = 3'd1;
  localparam logic [2:0] RD_ACK_RELEASE = 3'd2;
  localparam logic [2:0] RD_ACK_RISE   = 3'd3;
  localparam logic [2:0] RD_ACK_FALL   = 3'd4;

  // Configuration registers
  logic [6:0]  own_addr_q;
  logic [7:0]  idle_ticks_q;
  logic [31:0] reply_q;

  // Protocol state
  logic [2:0]     phase_q, phase_d;
  logic [2:0]     sub_q, sub_d;
  logic [2:0]     bit_cnt_q, bit_cnt_d;
  logic [7:0]     shift_q, shift_d;
  logic [1:0]     reply_idx_q, reply_idx_d;
  logic [7:0]     idle_cnt_q, idle_cnt_d;
  logic           drive_low_q, drive_low_d;
  logic           led_q, led_d;
  logic           prev_sda_q;
  logic [BcW-1:0] byte_cnt_q, byte_cnt_d;

  // Result register
  logic     out_valid_q;
  out_rsp_t out_q;
  out_rsp_t rsp;

  logic in_acc;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next-state logic for one line sample
  always_comb begin
    logic           scl, sda;
    logic           done, go_idle, rx_valid;
    logic [7:0]     rx_value;
    logic [7:0]     idle_inc;
    logic [3:0]     bit_inc;
    logic [1:0]     idx_inc;
    logic [BcW-1:0] byte_inc;

    scl = in_data_i.scl;
    sda = in_data_i.sda;
    done = 1'b0;
    go_idle = 1'b0;
    rx_valid = 1'b0;
    rx_value = 8'h00;
    idle_inc = (idle_cnt_q != 8'hFF) ? idle_cnt_q + 8'd1 : idle_cnt_q;
    bit_inc = {1'b0, bit_cnt_q} + 4'd1;
    idx_inc = reply_idx_q + 2'd1;
    byte_inc = byte_cnt_q + BcW'(1);

    phase_d     = phase_q;
    sub_d       = sub_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    reply_idx_d = reply_idx_q;
    idle_cnt_d  = idle_cnt_q;
    drive_low_d = drive_low_q;
    led_d       = led_q;
    byte_cnt_d  = byte_cnt_q;

    unique case (phase_q)
      PH_WAIT: begin
        drive_low_d = 1'b0;
        if (scl && sda) begin
          idle_cnt_d = idle_inc;
          if (idle_inc >= idle_ticks_q) phase_d = PH_ARMED;
        end else begin
          idle_cnt_d = 8'd0;
        end
      end
      PH_ARMED: begin
        // start: SDA falls while SCL is high
        if (prev_sda_q && !sda && scl) begin
          phase_d   = PH_ADDR;
          sub_d     = SS_WAIT_LOW;
          bit_cnt_d = 3'd0;
          shift_d   = 8'd0;
        end
      end
      PH_ADDR, PH_WRITE: begin
        unique case (sub_q)
          SS_WAIT_LOW: begin
            if (!scl) sub_d = SS_SAMPLE;
          end
          SS_SAMPLE: begin
            if (scl) begin
              shift_d = {shift_q[6:0], sda};
              sub_d   = sda ? SS_HOLD_ONE : SS_HOLD_ZERO;
            end
          end
          SS_HOLD_ONE: begin
            if (!scl) done = 1'b1;
          end
          SS_HOLD_ZERO: begin
            if (!scl) begin
              done = 1'b1;
            end else if (sda) begin
              // stop while a low bit is held
              if (phase_q == PH_WRITE) led_d = 1'b0;
              go_idle = 1'b1;
            end
          end
          SS_ACK_RISE: begin
            if (scl) sub_d = SS_ACK_FALL;
          end
          SS_ACK_FALL: begin
            if (!scl) begin
              drive_low_d = 1'b0;
              sub_d       = SS_SAMPLE;
              if (phase_q == PH_WRITE) begin
                rx_valid = 1'b1;
                rx_value = shift_q;
              end else if (shift_q[0]) begin
                led_d       = 1'b1;
                phase_d     = PH_READ;
                byte_cnt_d  = '0;
                reply_idx_d = 2'd0;
                bit_cnt_d   = 3'd0;
                drive_low_d = ~reply_q[31];
              end else begin
                phase_d = PH_WRITE;
              end
            end
          end
          default: go_idle = 1'b1;
        endcase
        // end of a data bit
        if (done) begin
          if (bit_inc[3]) begin
            bit_cnt_d = 3'd0;
            if (phase_q == PH_ADDR && shift_q[7:1] != own_addr_q) begin
              go_idle = 1'b1;
            end else begin
              drive_low_d = 1'b1;
              sub_d       = SS_ACK_RISE;
            end
          end else begin
            bit_cnt_d = bit_inc[2:0];
            sub_d     = SS_SAMPLE;
          end
        end
      end
      PH_READ: begin
        unique case (sub_q)
          RD_SETUP: begin
            if (!scl) begin
              drive_low_d = ~reply_q[{~reply_idx_q, ~bit_cnt_q}];
              sub_d       = RD_CLK_HIGH;
            end
          end
          RD_CLK_HIGH: begin
            if (scl) begin
              if (bit_inc[3]) begin
                bit_cnt_d = 3'd0;
                sub_d     = RD_ACK_RELEASE;
              end else begin
                bit_cnt_d = bit_inc[2:0];
                sub_d     = RD_SETUP;
              end
            end
          end
          RD_ACK_RELEASE: begin
            if (!scl) begin
              drive_low_d = 1'b0;
              sub_d       = RD_ACK_RISE;
            end
          end
          RD_ACK_RISE: begin
            if (scl) sub_d = RD_ACK_FALL;
          end
          RD_ACK_FALL: begin
            // master ACK bit ignored
            if (!scl) begin
              byte_cnt_d  = byte_inc;
              reply_idx_d = idx_inc;
              if (byte_inc >= BcW'(REPLY_BYTES)) begin
                go_idle = 1'b1;
              end else begin
                drive_low_d = ~reply_q[{~idx_inc, ~bit_cnt_q}];
                sub_d       = RD_CLK_HIGH;
              end
            end
          end
          default: go_idle = 1'b1;
        endcase
      end
      default: go_idle = 1'b1;
    endcase

    if (go_idle) begin
      phase_d     = PH_WAIT;
      sub_d       = SS_WAIT_LOW;
      idle_cnt_d  = 8'd0;
      bit_cnt_d   = 3'd0;
      drive_low_d = 1'b0;
    end

    rsp.sda_pull_low = drive_low_d;
    rsp.byte_valid   = rx_valid;
    rsp.byte_value   = rx_value;
    rsp.led          = led_d;
    rsp.phase        = phase_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q   <= OWN_ADDR_RST;
      idle_ticks_q <= IDLE_TICKS_RST;
      reply_q      <= REPLY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OWN_ADDR:   own_addr_q   <= cfg_wdata_i[6:0];
        CFG_IDLE_TICKS: idle_ticks_q <= cfg_wdata_i[7:0];
        CFG_REPLY:      reply_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Protocol state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      sub_q       <= SS_WAIT_LOW;
      bit_cnt_q   <= 3'd0;
      shift_q     <= 8'd0;
      reply_idx_q <= 2'd0;
      idle_cnt_q  <= 8'd0;
      drive_low_q <= 1'b0;
      led_q       <= 1'b0;
      prev_sda_q  <= 1'b1;
      byte_cnt_q  <= '0;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      sub_q       <= sub_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      reply_idx_q <= reply_idx_d;
      idle_cnt_q  <= idle_cnt_d;
      drive_low_q <= drive_low_d;
      led_q       <= led_d;
      prev_sda_q  <= in_data_i.sda;
      byte_cnt_q  <= byte_cnt_d;
    end
  end

  // Result register handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) out_q <= rsp;
  end

endmodule

// ===== src/i2cfr_checker.sv =====
// ---------------------------------------------------------------------------
// I2C target port checker
// Port-level properties of the result stream, bound to the target unit.
// ---------------------------------------------------------------------------
`include "i2c_target_fixed_reply_unit_defines.svh"

module i2cfr_checker import i2cfr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_rsp_t    out_data_o
);

  // A stalled result keeps its payload
  `I2CFR_ASSERT_NXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Every accepted request yields a result next cycle
  `I2CFR_ASSERT_NXT(a_result, in_valid_i && !in_stall_o, out_valid_o)

  // Received bytes only come out in the write phase
  `I2CFR_ASSERT_IMP(a_byte_phase, out_valid_o && out_data_o.byte_valid,
                    out_data_o.phase == PH_WRITE)

  // Read phase always shows the LED on
  `I2CFR_ASSERT_IMP(a_read_led, out_valid_o && out_data_o.phase == PH_READ,
                    out_data_o.led)

endmodule

bind i2c_target_fixed_reply_unit i2cfr_checker u_i2cfr_checker (.*);

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// I2C target with fixed reply: testbench
// Feeds SCL/SDA line samples as requests: a short table of hand-checked
// samples, then mostly well-formed bus transfers (write, read, wrong address)
// with random bit timing, mixed with broken transfers and line noise. The
// behavioral target model or the table gives each expected response, checked
// field by field, across several register settings including the extremes.
// ---------------------------------------------------------------------------
module testbench;
  import i2cfr_pkg::*;

  // Receive sub-steps, address and write phases
  localparam logic [2:0] RX_WAIT_LOW  = 3'd0;
  localparam logic [2:0] RX_WAIT_HIGH = 3'd1;
  localparam logic [2:0] RX_HELD_ONE  = 3'd2;
  localparam logic [2:0] RX_HELD_ZERO = 3'd3;
  localparam logic [2:0] RX_ACK_HIGH  = 3'd4;
  localparam logic [2:0] RX_ACK_LOW   = 3'd5;
  // Transmit sub-steps, read phase
  localparam logic [2:0] TX_SETUP     = 3'd0;
  localparam logic [2:0] TX_CLOCK     = 3'd1;
  localparam logic [2:0] TX_ACK_REL   = 3'd2;
  localparam logic [2:0] TX_ACK_HIGH  = 3'd3;
  localparam logic [2:0] TX_ACK_END   = 3'd4;

  // Bus activity generated by the random part
  localparam int XFER_WRITE  = 0;
  localparam int XFER_READ   = 1;
  localparam int XFER_MISS   = 2;
  localparam int XFER_BROKEN = 3;
  localparam int XFER_NOISE  = 4;
  localparam int XFER_PAUSE  = 5;

  // Receiver stall behavior
  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_HEAVY  = 2;
  localparam int STALL_TOGGLE = 3;

  typedef struct packed {
    in_req_t  pins;
    logic     typed;
    out_rsp_t want;
  } pin_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_req_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_rsp_t    out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = CFG_OWN_ADDR;
  logic [31:0] cfg_wdata_i = '0;

  i2c_target_fixed_reply_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Target model: register copies and protocol state
  logic [6:0]  own_addr_cfg;
  logic [7:0]  idle_need_cfg;
  logic [31:0] reply_word_cfg;
  logic [2:0]  bus_state;
  logic [2:0]  step;
  logic [3:0]  bits_seen;
  logic [7:0]  rx_shift;
  logic [1:0]  reply_sel;
  logic [7:0]  high_run;
  logic        pull_sda;
  logic        led_on;
  logic        sda_last;
  int unsigned bytes_sent;

  out_rsp_t pending_rsp_q[$];
  out_rsp_t oldest_rsp;
  in_req_t  line_q[$];
  pin_row_t directed_rows [22];
  int       mismatch_count = 0;
  int       burst_left = 0;
  int       stall_mode = STALL_NONE;
  int       stall_hold = 0;

  function automatic void return_to_wait();
    bus_state = PH_WAIT;
    step      = RX_WAIT_LOW;
    high_run  = '0;
    bits_seen = '0;
    pull_sda  = 1'b0;
  endfunction

  function automatic void target_reset();
    own_addr_cfg   = OWN_ADDR_RST;
    idle_need_cfg  = IDLE_TICKS_RST;
    reply_word_cfg = REPLY_RST;
    return_to_wait();
    rx_shift   = '0;
    reply_sel  = '0;
    led_on     = 1'b0;
    sda_last   = 1'b1;
    bytes_sent = 0;
  endfunction

  // Drive the current reply bit; a 0 bit pulls SDA low
  function automatic void load_reply_bit();
    logic [31:0] shifted;
    shifted  = reply_word_cfg >> (24 - 8 * reply_sel);
    pull_sda = !shifted[3'd7 - bits_seen[2:0]];
  endfunction

  // Advance the target by one line sample and return its response
  function automatic out_rsp_t next_target_rsp(in_req_t s);
    out_rsp_t rsp;
    logic     bit_done;
    rsp      = '0;
    bit_done = 1'b0;
    case (bus_state)
      PH_WAIT: begin
        pull_sda = 1'b0;
        if (s.scl && s.sda) begin
          if (high_run != 8'hff) high_run++;
          if (high_run >= idle_need_cfg) bus_state = PH_ARMED;
        end else begin
          high_run = '0;
        end
      end
      PH_ARMED: begin
        // start: SDA falls while SCL high
        if (sda_last && !s.sda && s.scl) begin
          bus_state = PH_ADDR;
          step      = RX_WAIT_LOW;
          bits_seen = '0;
          rx_shift  = '0;
        end
      end
      PH_ADDR, PH_WRITE: begin
        case (step)
          RX_WAIT_LOW: if (!s.scl) step = RX_WAIT_HIGH;
          RX_WAIT_HIGH: if (s.scl) begin
            rx_shift = {rx_shift[6:0], s.sda};
            step     = s.sda ? RX_HELD_ONE : RX_HELD_ZERO;
          end
          RX_HELD_ONE: if (!s.scl) bit_done = 1'b1;
          RX_HELD_ZERO: begin
            if (!s.scl) begin
              bit_done = 1'b1;
            end else if (s.sda) begin
              // stop while a zero bit is held
              if (bus_state == PH_WRITE) led_on = 1'b0;
              return_to_wait();
            end
          end
          RX_ACK_HIGH: if (s.scl) step = RX_ACK_LOW;
          RX_ACK_LOW: if (!s.scl) begin
            pull_sda = 1'b0;
            step     = RX_WAIT_HIGH;
            if (bus_state == PH_WRITE) begin
              rsp.byte_valid = 1'b1;
              rsp.byte_value = rx_shift;
            end else if (rx_shift[0]) begin
              led_on     = 1'b1;
              bus_state  = PH_READ;
              bytes_sent = 0;
              reply_sel  = '0;
              bits_seen  = '0;
              load_reply_bit();
            end else begin
              bus_state = PH_WRITE;
            end
          end
          default: return_to_wait();
        endcase
        if (bit_done) begin
          bits_seen++;
          if (bits_seen >= 4'd8) begin
            bits_seen = '0;
            if (bus_state == PH_ADDR && rx_shift[7:1] != own_addr_cfg) begin
              return_to_wait();
            end else begin
              pull_sda = 1'b1;
              step     = RX_ACK_HIGH;
            end
          end else begin
            step = RX_WAIT_HIGH;
          end
        end
      end
      PH_READ: begin
        case (step)
          TX_SETUP: if (!s.scl) begin
            load_reply_bit();
            step = TX_CLOCK;
          end
          TX_CLOCK: if (s.scl) begin
            bits_seen++;
            if (bits_seen >= 4'd8) begin
              bits_seen = '0;
              step      = TX_ACK_REL;
            end else begin
              step = TX_SETUP;
            end
          end
          TX_ACK_REL: if (!s.scl) begin
            pull_sda = 1'b0;
            step     = TX_ACK_HIGH;
          end
          TX_ACK_HIGH: if (s.scl) step = TX_ACK_END;
          // master ACK ignored; move to the next reply byte
          TX_ACK_END: if (!s.scl) begin
            bytes_sent++;
            reply_sel++;
            if (bytes_sent >= REPLY_BYTES_DEF) begin
              return_to_wait();
            end else begin
              load_reply_bit();
              step = TX_CLOCK;
            end
          end
          default: return_to_wait();
        endcase
      end
      default: return_to_wait();
    endcase
    sda_last         = s.sda;
    rsp.sda_pull_low = pull_sda;
    rsp.led          = led_on;
    rsp.phase        = bus_state;
    return rsp;
  endfunction

  function automatic pin_row_t sample_row(logic scl, logic sda, logic typed, logic [2:0] ph);
    pin_row_t r;
    r.pins       = {scl, sda};
    r.typed      = typed;
    r.want       = '0;
    r.want.phase = ph;
    return r;
  endfunction

  // Line sequence builders
  function automatic void add_pins(logic scl, logic sda, int n);
    for (int i = 0; i < n; i++) line_q.push_back({scl, sda});
  endfunction

  function automatic void add_bit(logic b);
    add_pins(1'b0, b, $urandom_range(1, 3));
    add_pins(1'b1, b, $urandom_range(1, 3));
  endfunction

  function automatic void add_byte(logic [7:0] v, logic ack);
    for (int i = 7; i >= 0; i--) add_bit(v[i]);
    add_bit(ack);
  endfunction

  function automatic void add_start();
    int need;
    need = (idle_need_cfg == 8'd0) ? 1 : int'(idle_need_cfg);
    add_pins(1'b1, 1'b1, need + $urandom_range(0, 3));
    add_pins(1'b1, 1'b0, $urandom_range(1, 2));
  endfunction

  function automatic void add_stop();
    add_pins(1'b0, 1'b0, $urandom_range(1, 3));
    add_pins(1'b1, 1'b0, $urandom_range(1, 3));
    add_pins(1'b1, 1'b1, $urandom_range(1, 3));
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Send one request; the sender works in bursts separated by gaps
  task automatic send_sample(in_req_t pins, out_rsp_t want);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 250 : $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= pins;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_rsp_q.push_back(want);
    burst_left--;
  endtask

  task automatic play_lines();
    foreach (line_q[i]) send_sample(line_q[i], next_target_rsp(line_q[i]));
    line_q.delete();
  endtask

  task automatic wait_for_responses();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_OWN_ADDR:   own_addr_cfg   = data[6:0];
      CFG_IDLE_TICKS: idle_need_cfg  = data[7:0];
      CFG_REPLY:      reply_word_cfg = data;
      default: ;
    endcase
  endtask

  // Registers change only with no request in flight
  task automatic apply_setting(logic [6:0] addr, logic [7:0] idle, logic [31:0] reply);
    wait_for_responses();
    repeat (2) @(posedge clk_i);
    write_reg(CFG_OWN_ADDR, {25'd0, addr});
    write_reg(CFG_IDLE_TICKS, {24'd0, idle});
    write_reg(CFG_REPLY, reply);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random bus traffic until the sample budget is used up
  task automatic run_transfers(int budget);
    int         sent;
    int         pick;
    int         kind;
    logic [6:0] other_addr;
    logic       rw;
    sent = 0;
    do begin
      pick = $urandom_range(0, 19);
      kind = (pick < 7)  ? XFER_WRITE :
             (pick < 14) ? XFER_READ :
             (pick < 16) ? XFER_MISS :
             (pick < 18) ? XFER_BROKEN :
             (pick < 19) ? XFER_NOISE : XFER_PAUSE;
      case (kind)
        XFER_WRITE: begin
          add_start();
          add_byte({own_addr_cfg, 1'b0}, 1'b1);
          repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)), 1'b1);
          add_stop();
        end
        XFER_READ: begin
          add_start();
          add_byte({own_addr_cfg, 1'b1}, 1'b1);
          // master clocks all reply bytes; its SDA level is don't-care
          repeat (9 * REPLY_BYTES_DEF) add_bit(1'($urandom_range(0, 1)));
          add_stop();
        end
        XFER_MISS: begin
          other_addr = 7'($urandom_range(0, 127));
          if (other_addr == own_addr_cfg) other_addr = other_addr + 7'd1;
          rw = 1'($urandom_range(0, 1));
          add_start();
          add_byte({other_addr, rw}, 1'b1);
          add_byte(8'($urandom_range(0, 255)), 1'b1);
          add_stop();
        end
        XFER_BROKEN: begin
          // transfer cut short by a stop mid-byte
          add_start();
          if ($urandom_range(0, 1)) add_byte({own_addr_cfg, 1'b0}, 1'b1);
          repeat ($urandom_range(1, 7)) add_bit(1'($urandom_range(0, 1)));
          add_stop();
        end
        XFER_NOISE: begin
          repeat ($urandom_range(1, 24))
            add_pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
        end
        default: wait_for_responses();
      endcase
      sent += line_q.size();
      play_lines();
    end while (sent < budget);
  endtask

  // Receiver stall pattern, switching to a random behavior when its hold runs out
  always @(posedge clk_i) begin
    if (stall_hold == 0) begin
      stall_mode <= $urandom_range(STALL_NONE, STALL_TOGGLE);
      stall_hold <= $urandom_range(20, 120);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ~out_stall_i;
    endcase
  end

  // Response checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected response", 32'(out_data_o), 32'd0);
      end else begin
        oldest_rsp = pending_rsp_q.pop_front();
        if (out_data_o.sda_pull_low !== oldest_rsp.sda_pull_low)
          report_mismatch("sda_pull_low", 32'(out_data_o.sda_pull_low),
                          32'(oldest_rsp.sda_pull_low));
        if (out_data_o.byte_valid !== oldest_rsp.byte_valid)
          report_mismatch("byte_valid", 32'(out_data_o.byte_valid),
                          32'(oldest_rsp.byte_valid));
        if (out_data_o.byte_value !== oldest_rsp.byte_value)
          report_mismatch("byte_value", 32'(out_data_o.byte_value),
                          32'(oldest_rsp.byte_value));
        if (out_data_o.led !== oldest_rsp.led)
          report_mismatch("led", 32'(out_data_o.led), 32'(oldest_rsp.led));
        if (out_data_o.phase !== oldest_rsp.phase)
          report_mismatch("phase", 32'(out_data_o.phase), 32'(oldest_rsp.phase));
      end
    end
  end

  initial begin
    out_rsp_t predicted;
    target_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle arming, start with wait for SCL low, stop in the address phase
    directed_rows = '{
      sample_row(1'b0, 1'b0, 1'b1, PH_WAIT),
      sample_row(1'b1, 1'b0, 1'b1, PH_WAIT),
      sample_row(1'b0, 1'b1, 1'b1, PH_WAIT),
      sample_row(1'b1, 1'b1, 1'b1, PH_WAIT),
      sample_row(1'b1, 1'b1, 1'b1, PH_WAIT),
      sample_row(1'b1, 1'b1, 1'b1, PH_WAIT),
      sample_row(1'b1, 1'b1, 1'b1, PH_WAIT),
      sample_row(1'b1, 1'b1, 1'b1, PH_ARMED),
      sample_row(1'b1, 1'b1, 1'b1, PH_ARMED),
      sample_row(1'b0, 1'b0, 1'b1, PH_ARMED),
      sample_row(1'b0, 1'b1, 1'b1, PH_ARMED),
      sample_row(1'b1, 1'b1, 1'b1, PH_ARMED),
      sample_row(1'b1, 1'b0, 1'b1, PH_ADDR),
      sample_row(1'b1, 1'b0, 1'b1, PH_ADDR),
      sample_row(1'b0, 1'b1, 1'b1, PH_ADDR),
      sample_row(1'b1, 1'b1, 1'b1, PH_ADDR),
      sample_row(1'b1, 1'b0, 1'b1, PH_ADDR),
      sample_row(1'b0, 1'b0, 1'b1, PH_ADDR),
      sample_row(1'b1, 1'b0, 1'b1, PH_ADDR),
      sample_row(1'b1, 1'b1, 1'b1, PH_WAIT),
      sample_row(1'b1, 1'b1, 1'b0, PH_WAIT),
      sample_row(1'b1, 1'b1, 1'b0, PH_WAIT)
    };
    foreach (directed_rows[i]) begin
      predicted = next_target_rsp(directed_rows[i].pins);
      send_sample(directed_rows[i].pins,
                  directed_rows[i].typed ? directed_rows[i].want : predicted);
    end

    // Random traffic under several register settings
    run_transfers(50);
    apply_setting(7'h00, 8'd1, 32'h0000_0000);
    run_transfers(50);
    apply_setting(7'h7f, 8'd255, 32'hffff_ffff);
    run_transfers(120);
    apply_setting(7'($urandom_range(0, 127)), 8'd0, $urandom);
    run_transfers(50);
    apply_setting(7'($urandom_range(0, 127)), 8'($urandom_range(1, 8)), $urandom);
    run_transfers(50);

    wait_for_responses();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
